>>> src/mhtq_pkg.sv
// Shared types, codes and constants of the timer queue.
`default_nettype none
package mhtq_pkg;

    localparam int ID_W        = 10;
    localparam int TO_W        = 31;
    localparam int KIND_W      = 2;
    localparam int RK_W        = 3;
    localparam int MAX_EXPIRED = 32;
    localparam int K_W         = $clog2(MAX_EXPIRED + 1);

    localparam int CAPACITY_DEF  = 32;
    localparam int ID_COUNT_DEF  = 1024;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [TO_W-1:0] DELAY_MAX = {TO_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    typedef enum logic [RK_W-1:0] {
        RK_EXPIRED   = 3'd0,
        RK_DELAY     = 3'd1,
        RK_EMPTY     = 3'd2,
        RK_INSERTED  = 3'd3,
        RK_REFRESHED = 3'd4,
        RK_DROPPED   = 3'd5
    } rkind_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RD_MAP,
        OP_RD_SLOT,
        OP_ADD_REFRESH,
        OP_ADD_NEW,
        OP_RD_L,
        OP_RD_R,
        OP_SEL,
        OP_DN_SWAP,
        OP_RD_P,
        OP_UP_SWAP,
        OP_PLACE,
        OP_RD_TOP,
        OP_TAKE,
        OP_RD_LAST,
        OP_REM,
        OP_EMIT_ADD,
        OP_EMIT_PEND,
        OP_EMIT_Q
    } op_t;

    typedef struct packed {
        op_t    op;
        rkind_t rkind;
        logic   last;
    } cmd_t;

    typedef struct packed {
        logic c_ge_n;
        logic e_before_ch;
        logic i_zero;
        logic par_before_e;
        logic moved;
        logic cnt_zero;
        logic full;
        logic top_due;
        logic k_full;
        logic pend_v;
        logic out_free;
        logic present;
        logic id_oob;
        logic is_query;
    } stat_t;

endpackage
`default_nettype wire

>>> src/mhtq_ctrl.sv
// Sequencer of the timer queue: add, drain, sift and emit steps.
`default_nettype none
module mhtq_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    input  wire logic [mhtq_pkg::KIND_W-1:0]  s_kind,
    output logic                              s_ready,
    input  wire mhtq_pkg::stat_t              stat,
    output mhtq_pkg::cmd_t                    cmd
);
    import mhtq_pkg::*;

    typedef enum logic [16:0] {
        ST_IDLE    = 17'h00001,
        ST_ADD_CHK = 17'h00002,
        ST_SLOT_RD = 17'h00004,
        ST_ADD_DEC = 17'h00008,
        ST_DN_L    = 17'h00010,
        ST_DN_R    = 17'h00020,
        ST_DN_SEL  = 17'h00040,
        ST_DN_CMP  = 17'h00080,
        ST_UP_P    = 17'h00100,
        ST_UP_CMP  = 17'h00200,
        ST_PLACE   = 17'h00400,
        ST_EMIT    = 17'h00800,
        ST_TOP_RD  = 17'h01000,
        ST_TOP_CHK = 17'h02000,
        ST_LAST_RD = 17'h04000,
        ST_REM     = 17'h08000,
        ST_FIN     = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    rkind_t akind_reg, akind_next;
    logic   drain_reg, drain_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        akind_next = akind_reg;
        drain_next = drain_reg;
        cmd.op     = OP_NONE;
        cmd.rkind  = akind_reg;
        cmd.last   = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_ACCEPT;
                    drain_next = (s_kind != KIND_ADD);
                    if (s_kind == KIND_ADD) begin
                        state_next = ST_ADD_CHK;
                    end else if (s_kind == KIND_CLEAR) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_TOP_RD;
                    end
                end
            end
            ST_ADD_CHK: begin
                cmd.op = OP_RD_MAP;
                if (stat.id_oob) begin
                    akind_next = RK_DROPPED;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_SLOT_RD;
                end
            end
            ST_SLOT_RD: begin
                cmd.op     = OP_RD_SLOT;
                state_next = ST_ADD_DEC;
            end
            ST_ADD_DEC: begin
                if (stat.present) begin
                    cmd.op     = OP_ADD_REFRESH;
                    akind_next = RK_REFRESHED;
                    state_next = ST_DN_L;
                end else if (stat.full) begin
                    akind_next = RK_DROPPED;
                    state_next = ST_EMIT;
                end else begin
                    cmd.op     = OP_ADD_NEW;
                    akind_next = RK_INSERTED;
                    state_next = ST_UP_P;
                end
            end
            ST_DN_L: begin
                if (stat.c_ge_n) begin
                    // A refreshed timer that did not sink may still need to rise.
                    state_next = (stat.moved || drain_reg) ? ST_PLACE : ST_UP_P;
                end else begin
                    cmd.op     = OP_RD_L;
                    state_next = ST_DN_R;
                end
            end
            ST_DN_R: begin
                cmd.op     = OP_RD_R;
                state_next = ST_DN_SEL;
            end
            ST_DN_SEL: begin
                cmd.op     = OP_SEL;
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                if (stat.e_before_ch) begin
                    state_next = (stat.moved || drain_reg) ? ST_PLACE : ST_UP_P;
                end else begin
                    cmd.op     = OP_DN_SWAP;
                    state_next = ST_DN_L;
                end
            end
            ST_UP_P: begin
                if (stat.i_zero) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.op     = OP_RD_P;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (stat.par_before_e) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.op     = OP_UP_SWAP;
                    state_next = ST_UP_P;
                end
            end
            ST_PLACE: begin
                cmd.op     = OP_PLACE;
                state_next = drain_reg ? ST_TOP_RD : ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op     = OP_EMIT_ADD;
                    state_next = ST_IDLE;
                end
            end
            ST_TOP_RD: begin
                cmd.op     = OP_RD_TOP;
                state_next = ST_TOP_CHK;
            end
            ST_TOP_CHK: begin
                if (!stat.cnt_zero && !stat.k_full && stat.top_due) begin
                    // The previous expired word is sent only now that another follows.
                    if (!stat.pend_v || stat.out_free) begin
                        cmd.op     = OP_TAKE;
                        cmd.last   = 1'b0;
                        state_next = ST_LAST_RD;
                    end
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_LAST_RD: begin
                cmd.op     = OP_RD_LAST;
                state_next = ST_REM;
            end
            ST_REM: begin
                cmd.op     = OP_REM;
                state_next = ST_DN_L;
            end
            ST_FIN: begin
                if (stat.pend_v) begin
                    if (stat.out_free) begin
                        cmd.op   = OP_EMIT_PEND;
                        cmd.last = !stat.is_query;
                        if (!stat.is_query) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else if (!stat.is_query) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.op     = OP_EMIT_Q;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            akind_reg <= RK_DROPPED;
            drain_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            akind_reg <= akind_next;
            drain_reg <= drain_next;
        end
    end

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_ACCEPT) |-> (state_reg == ST_IDLE))
        else $error("item taken outside idle");

    a_rem_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REM) |-> ($past(state_reg) == ST_LAST_RD))
        else $error("removal without reading the last slot");

    property p_take_then_read;
        @(posedge aclk) disable iff (!aresetn)
            (cmd.op == OP_TAKE) |=> (state_reg == ST_LAST_RD);
    endproperty
    a_take_then_read: assert property (p_take_then_read)
        else $error("take not followed by last-slot read");

endmodule
`default_nettype wire

>>> src/mhtq_dp.sv
// Datapath of the timer queue: heap and id map memories, time, output register.
`default_nettype none
module mhtq_dp #(
    parameter int CAPACITY  = mhtq_pkg::CAPACITY_DEF,
    parameter int ID_COUNT  = mhtq_pkg::ID_COUNT_DEF,
    parameter int TIME_BITS = mhtq_pkg::TIME_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [mhtq_pkg::KIND_W-1:0] s_kind,
    input  wire logic [mhtq_pkg::ID_W-1:0]   s_timer_id,
    input  wire logic [mhtq_pkg::TO_W-1:0]   s_timeout_ms,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mhtq_pkg::RK_W-1:0]        m_result_kind,
    output logic [mhtq_pkg::ID_W-1:0]        m_expired_id,
    output logic [mhtq_pkg::TO_W-1:0]        m_delay_ms,
    output logic                             m_last,
    input  wire mhtq_pkg::cmd_t              cmd,
    output mhtq_pkg::stat_t                  stat
);
    import mhtq_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CW     = SLOT_W + 2;
    localparam int IDX_W  = $clog2(ID_COUNT);
    localparam int ENT_W  = ID_W + TIME_BITS;

    function automatic logic earlier(input logic [TIME_BITS-1:0] a,
                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] d;
        d = a - b;
        return d[TIME_BITS-1];
    endfunction

    function automatic logic [IDX_W-1:0] id_index(input logic [ID_W-1:0] id);
        logic [16:0] w;
        w = 17'(id);
        return w[IDX_W-1:0];
    endfunction

    logic [ENT_W-1:0]  heap_mem [CAPACITY];
    logic [SLOT_W-1:0] map_mem  [ID_COUNT];

    logic [KIND_W-1:0]    in_kind_reg, in_kind_next;
    logic [ID_W-1:0]      in_id_reg, in_id_next;
    logic [TO_W-1:0]      in_to_reg, in_to_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [ID_W-1:0]      e_id_reg, e_id_next;
    logic [TIME_BITS-1:0] e_exp_reg, e_exp_next;
    logic [ID_W-1:0]      ch_id_reg, ch_id_next;
    logic [TIME_BITS-1:0] ch_exp_reg, ch_exp_next;
    logic                 ch_r_reg, ch_r_next;
    logic [SLOT_W-1:0]    i_reg, i_next;
    logic                 moved_reg, moved_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic [ID_W-1:0]      pend_reg, pend_next;
    logic                 pend_v_reg, pend_v_next;
    logic [ENT_W-1:0]     rd_reg;
    logic [SLOT_W-1:0]    map_q_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [RK_W-1:0]      m_kind_reg, m_kind_next;
    logic [ID_W-1:0]      m_id_reg, m_id_next;
    logic [TO_W-1:0]      m_delay_reg, m_delay_next;
    logic                 m_last_reg, m_last_next;

    logic [ID_W-1:0]      rd_id;
    logic [TIME_BITS-1:0] rd_exp;
    logic [CW-1:0]        c_w, c1_w, n_w;
    logic                 has_r, sel_r, out_free, emit;
    logic [SLOT_W-1:0]    par_slot, last_slot;
    logic [TIME_BITS-1:0] top_d, exp_new;
    logic [63:0]          sum64, d64;
    logic                 top_due;
    logic [TO_W-1:0]      delay;
    logic                 h_re, h_we, m_we;
    logic [SLOT_W-1:0]    h_raddr, h_waddr;
    logic [ENT_W-1:0]     h_wdata;
    logic [ID_W-1:0]      m_wid;

    assign rd_id     = rd_reg[ENT_W-1:TIME_BITS];
    assign rd_exp    = rd_reg[TIME_BITS-1:0];
    assign c_w       = CW'({i_reg, 1'b1});
    assign c1_w      = c_w + CW'(1);
    assign n_w       = CW'(n_reg);
    assign has_r     = c1_w < n_w;
    assign sel_r     = has_r && earlier(rd_exp, ch_exp_reg);
    assign par_slot  = SLOT_W'((i_reg - SLOT_W'(1)) >> 1);
    assign last_slot = SLOT_W'(cnt_reg - CNT_W'(1));
    assign sum64     = 64'(time_reg) + 64'(in_to_reg);
    assign exp_new   = sum64[TIME_BITS-1:0];
    assign top_d     = rd_exp - time_reg;
    assign top_due   = (top_d == '0) || top_d[TIME_BITS-1];
    assign d64       = 64'(top_d);
    assign delay     = top_due ? '0 : ((d64 > 64'(DELAY_MAX)) ? DELAY_MAX : d64[TO_W-1:0]);
    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = (cmd.op == OP_EMIT_ADD) || (cmd.op == OP_EMIT_PEND)
                       || (cmd.op == OP_EMIT_Q)
                       || ((cmd.op == OP_TAKE) && pend_v_reg);

    always_comb begin
        stat.c_ge_n       = c_w >= n_w;
        stat.e_before_ch  = earlier(e_exp_reg, ch_exp_reg);
        stat.i_zero       = (i_reg == '0);
        stat.par_before_e = earlier(rd_exp, e_exp_reg);
        stat.moved        = moved_reg;
        stat.cnt_zero     = (cnt_reg == '0);
        stat.full         = cnt_reg >= CNT_W'(CAPACITY);
        stat.top_due      = top_due;
        stat.k_full       = k_reg >= K_W'(MAX_EXPIRED);
        stat.pend_v       = pend_v_reg;
        stat.out_free     = out_free;
        // An id is present exactly when its mapped slot is live and holds it.
        stat.present      = (CNT_W'(map_q_reg) < cnt_reg) && (rd_id == in_id_reg);
        stat.id_oob       = 17'(in_id_reg) >= 17'(ID_COUNT);
        stat.is_query     = (in_kind_reg == KIND_QUERY);
    end

    // Memory port selection.
    always_comb begin
        h_re    = 1'b1;
        h_raddr = '0;
        case (cmd.op)
            OP_RD_SLOT: h_raddr = map_q_reg;
            OP_RD_L:    h_raddr = c_w[SLOT_W-1:0];
            OP_RD_R:    h_raddr = c1_w[SLOT_W-1:0];
            OP_RD_P:    h_raddr = par_slot;
            OP_RD_TOP:  h_raddr = '0;
            OP_RD_LAST: h_raddr = last_slot;
            default:    h_re    = 1'b0;
        endcase
        h_we    = 1'b1;
        h_waddr = i_reg;
        h_wdata = {e_id_reg, e_exp_reg};
        case (cmd.op)
            OP_DN_SWAP: h_wdata = {ch_id_reg, ch_exp_reg};
            OP_UP_SWAP: h_wdata = rd_reg;
            OP_PLACE:   h_wdata = {e_id_reg, e_exp_reg};
            default:    h_we    = 1'b0;
        endcase
        m_we  = h_we;
        m_wid = h_wdata[ENT_W-1:TIME_BITS];
    end

    always_ff @(posedge aclk) begin
        if (h_we) begin
            heap_mem[h_waddr] <= h_wdata;
        end
        if (h_re) begin
            rd_reg <= heap_mem[h_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (m_we) begin
            map_mem[id_index(m_wid)] <= h_waddr;
        end
        if (cmd.op == OP_RD_MAP) begin
            map_q_reg <= map_mem[id_index(in_id_reg)];
        end
    end

    always_comb begin
        in_kind_next = in_kind_reg;
        in_id_next   = in_id_reg;
        in_to_next   = in_to_reg;
        time_next    = time_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        e_id_next    = e_id_reg;
        e_exp_next   = e_exp_reg;
        ch_id_next   = ch_id_reg;
        ch_exp_next  = ch_exp_reg;
        ch_r_next    = ch_r_reg;
        i_next       = i_reg;
        moved_next   = moved_reg;
        k_next       = k_reg;
        pend_next    = pend_reg;
        pend_v_next  = pend_v_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_id_next    = m_id_reg;
        m_delay_next = m_delay_reg;
        m_last_next  = m_last_reg;
        case (cmd.op)
            OP_ACCEPT: begin
                in_kind_next = s_kind;
                in_id_next   = s_timer_id;
                in_to_next   = s_timeout_ms;
                k_next       = '0;
                pend_v_next  = 1'b0;
                if (s_kind == KIND_TICK) begin
                    time_next = time_reg + TIME_BITS'(1);
                end
                if (s_kind == KIND_CLEAR) begin
                    cnt_next = '0;
                end
            end
            OP_ADD_REFRESH: begin
                e_id_next  = in_id_reg;
                e_exp_next = exp_new;
                i_next     = map_q_reg;
                n_next     = cnt_reg;
                moved_next = 1'b0;
            end
            OP_ADD_NEW: begin
                e_id_next  = in_id_reg;
                e_exp_next = exp_new;
                i_next     = cnt_reg[SLOT_W-1:0];
                cnt_next   = cnt_reg + CNT_W'(1);
                moved_next = 1'b0;
            end
            OP_RD_R: begin
                ch_id_next  = rd_id;
                ch_exp_next = rd_exp;
                ch_r_next   = 1'b0;
            end
            OP_SEL: begin
                if (sel_r) begin
                    ch_id_next  = rd_id;
                    ch_exp_next = rd_exp;
                    ch_r_next   = 1'b1;
                end
            end
            OP_DN_SWAP: begin
                i_next     = ch_r_reg ? c1_w[SLOT_W-1:0] : c_w[SLOT_W-1:0];
                moved_next = 1'b1;
            end
            OP_UP_SWAP: begin
                i_next = par_slot;
            end
            OP_TAKE: begin
                pend_next   = rd_id;
                pend_v_next = 1'b1;
                k_next      = k_reg + K_W'(1);
                // The output register may still hold an earlier word waiting to be taken.
                if (pend_v_reg) begin
                    m_kind_next  = RK_EXPIRED;
                    m_id_next    = pend_reg;
                    m_delay_next = '0;
                    m_last_next  = 1'b0;
                end
            end
            OP_REM: begin
                cnt_next   = cnt_reg - CNT_W'(1);
                n_next     = cnt_reg - CNT_W'(1);
                e_id_next  = rd_id;
                e_exp_next = rd_exp;
                i_next     = '0;
                moved_next = 1'b0;
            end
            OP_EMIT_ADD: begin
                m_kind_next  = cmd.rkind;
                m_id_next    = in_id_reg;
                m_delay_next = '0;
                m_last_next  = 1'b1;
            end
            OP_EMIT_PEND: begin
                m_kind_next  = RK_EXPIRED;
                m_id_next    = pend_reg;
                m_delay_next = '0;
                m_last_next  = cmd.last;
                pend_v_next  = 1'b0;
            end
            OP_EMIT_Q: begin
                m_kind_next  = (cnt_reg == '0) ? RK_EMPTY : RK_DELAY;
                m_id_next    = '0;
                m_delay_next = (cnt_reg == '0) ? '0 : delay;
                m_last_next  = 1'b1;
            end
            default: begin
            end
        endcase
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg    <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            in_kind_reg <= KIND_CLEAR;
            moved_reg   <= 1'b0;
        end else begin
            time_reg    <= time_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            pend_v_reg  <= pend_v_next;
            m_valid_reg <= m_valid_next;
            in_kind_reg <= in_kind_next;
            moved_reg   <= moved_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_id_reg   <= in_id_next;
        in_to_reg   <= in_to_next;
        n_reg       <= n_next;
        e_id_reg    <= e_id_next;
        e_exp_reg   <= e_exp_next;
        ch_id_reg   <= ch_id_next;
        ch_exp_reg  <= ch_exp_next;
        ch_r_reg    <= ch_r_next;
        i_reg       <= i_next;
        pend_reg    <= pend_next;
        m_kind_reg  <= m_kind_next;
        m_id_reg    <= m_id_next;
        m_delay_reg <= m_delay_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_expired_id  = m_id_reg;
    assign m_delay_ms    = m_delay_reg;
    assign m_last        = m_last_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("heap count beyond capacity");

    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= K_W'(MAX_EXPIRED))
        else $error("too many expired words for one item");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("output word overwritten");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_ACCEPT && s_kind == KIND_CLEAR) |=> (cnt_reg == '0))
        else $error("clear left timers in the heap");

endmodule
`default_nettype wire

>>> src/min_heap_timer_queue_top.sv
// Top level of the timer queue: sequencer and datapath.
`default_nettype none
// Timer queue built on a binary min-heap held in a single-port-read memory, with an
// id-to-slot map in a second memory. Items are taken one at a time. An add reads the map
// and the mapped slot, then a left read, right read, select and compare for each level a
// timer sinks, or a parent read and compare for each level it rises. Each timer expired
// by a tick or query takes a top read, a last-slot read and a removal, then a re-heap
// where each level needs a registered heap read for each child. A tick or query ends with a
// final look at the heap top; a query adds its delay word. Each result waits in an output
// register until taken; the block stalls while it is full. No clearing pass follows reset.
module min_heap_timer_queue_top #(
    parameter int CAPACITY  = mhtq_pkg::CAPACITY_DEF,
    parameter int ID_COUNT  = mhtq_pkg::ID_COUNT_DEF,
    parameter int TIME_BITS = mhtq_pkg::TIME_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [mhtq_pkg::KIND_W-1:0] s_kind,
    input  wire logic [mhtq_pkg::ID_W-1:0]   s_timer_id,
    input  wire logic [mhtq_pkg::TO_W-1:0]   s_timeout_ms,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mhtq_pkg::RK_W-1:0]        m_result_kind,
    output logic [mhtq_pkg::ID_W-1:0]        m_expired_id,
    output logic [mhtq_pkg::TO_W-1:0]        m_delay_ms,
    output logic                             m_last
);
    import mhtq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mhtq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mhtq_dp #(
        .CAPACITY  (CAPACITY),
        .ID_COUNT  (ID_COUNT),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_kind        (s_kind),
        .s_timer_id    (s_timer_id),
        .s_timeout_ms  (s_timeout_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_expired_id  (m_expired_id),
        .m_delay_ms    (m_delay_ms),
        .m_last        (m_last),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
`default_nettype wire
